@@ design/rse_pkg.sv @@
// Shared types and constants for the rotating stack engine.
package rse_pkg;

	localparam int DEPTH = 512;
	localparam int DATA_W = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_POP  = 3'd1,
		CMD_SWAP = 3'd2,
		CMD_ROT  = 3'd3,
		CMD_RROT = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_SWAP,
		OP_ROT,
		OP_RROT
	} cell_op_t;

	typedef struct packed {
		logic [2:0] command;
		data_t      value;
	} req_t;

	typedef struct packed {
		logic             ok;
		data_t            popped;
		logic [CNT_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		cell_op_t         op;
		data_t            value;
		data_t            a_top;
		data_t            b_bot;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] cnt_m1;
		logic [CNT_W-1:0] cnt_m2;
	} cell_ctrl_t;

endpackage

@@ design/rotating_stack_engine.sv @@
// Top level of the rotating stack engine: command decode, element count and result register.
//
//   Port     Dir   Content
//   start    in    request strobe, taken when busy is low
//   req      in    command and value of the request
//   busy     out   always low, a request is taken in every cycle
//   done     out   one-cycle result strobe
//   rsp      out   ok flag, popped element and occupancy
//
// Each request is finished at the edge that takes it: every cell of the row updates at that
// edge, so the next request may follow in the next cycle.
// The result is registered for the cycle after the request; done marks it for a single cycle.
// Reset clears the element count and the result strobe; the cell contents are not reset.
// The receiver cannot stall the result, and nothing inside waits on it.
module rotating_stack_engine import rse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             take;
	logic             ok;
	logic             two_plus;
	logic             full;
	logic             empty;
	data_t            popped;
	cell_op_t         op;
	cell_ctrl_t       ctrl;
	data_t            a_top;
	data_t            b_bot;
	logic             done_q;
	rsp_t             rsp_q;

	assign busy     = 1'b0;
	assign take     = start & ~busy;
	assign two_plus = (cnt_q > CNT_W'(1));
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);

	always_comb begin
		op     = OP_HOLD;
		ok     = 1'b0;
		popped = '0;
		cnt_d  = cnt_q;
		case (req.command)
			CMD_PUSH: begin
				if (!full) begin
					op    = OP_PUSH;
					ok    = 1'b1;
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (!empty) begin
					op     = OP_POP;
					ok     = 1'b1;
					popped = a_top;
					cnt_d  = cnt_q - CNT_W'(1);
				end
			end
			CMD_SWAP: begin
				if (two_plus) begin
					op = OP_SWAP;
					ok = 1'b1;
				end
			end
			CMD_ROT: begin
				ok = 1'b1;
				if (two_plus) begin
					op = OP_ROT;
				end
			end
			CMD_RROT: begin
				ok = 1'b1;
				if (two_plus) begin
					op = OP_RROT;
				end
			end
			default: begin
				op = OP_HOLD;
				ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctrl.op     = take ? op : OP_HOLD;
		ctrl.value  = req.value;
		ctrl.a_top  = a_top;
		ctrl.b_bot  = b_bot;
		ctrl.cnt    = cnt_q;
		ctrl.cnt_m1 = cnt_q - CNT_W'(1);
		ctrl.cnt_m2 = cnt_q - CNT_W'(2);
	end

	rse_chain u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.a_top (a_top),
		.b_bot (b_bot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.ok        <= ok;
			rsp_q.popped    <= popped;
			rsp_q.occupancy <= cnt_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ design/rse_cell.sv @@
// One stack cell: holds one element counted from the top and one counted from the bottom.
module rse_cell import rse_pkg::*; (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] idx,
	input  data_t            a_prev,
	input  data_t            a_next,
	input  data_t            b_prev,
	input  data_t            b_next,
	output data_t            a_q,
	output data_t            b_q
);

	logic [CNT_W-1:0] pos;
	logic             is_first;
	logic             is_second;
	logic             is_cnt;
	logic             is_last;
	logic             is_pen;
	data_t            a_d;
	data_t            b_d;

	assign pos       = CNT_W'(idx);
	assign is_first  = (pos == '0);
	assign is_second = (pos == CNT_W'(1));
	assign is_cnt    = (pos == ctrl.cnt);
	assign is_last   = (pos == ctrl.cnt_m1);
	assign is_pen    = (pos == ctrl.cnt_m2);

	always_comb begin
		a_d = a_q;
		b_d = b_q;
		case (ctrl.op)
			OP_PUSH: begin
				a_d = is_first ? ctrl.value : a_prev;
				if (is_cnt) begin
					b_d = ctrl.value;
				end
			end
			OP_POP: begin
				a_d = a_next;
			end
			OP_SWAP: begin
				if (is_first) begin
					a_d = a_next;
				end else if (is_second) begin
					a_d = a_prev;
				end
				if (is_last) begin
					b_d = b_prev;
				end else if (is_pen) begin
					b_d = b_next;
				end
			end
			OP_ROT: begin
				a_d = is_last ? ctrl.a_top : a_next;
				b_d = is_first ? ctrl.a_top : b_prev;
			end
			OP_RROT: begin
				a_d = is_first ? ctrl.b_bot : a_prev;
				b_d = is_last ? ctrl.b_bot : b_next;
			end
			default: begin
				a_d = a_q;
				b_d = b_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		a_q <= a_d;
		b_q <= b_d;
	end

endmodule

@@ design/rse_chain.sv @@
// Row of stack cells linked to their neighbors on both sides.
module rse_chain import rse_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	output data_t      a_top,
	output data_t      b_bot
);

	data_t a_w [DEPTH];
	data_t b_w [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		data_t a_prev;
		data_t a_next;
		data_t b_prev;
		data_t b_next;

		if (i == 0) begin : g_head
			assign a_prev = a_w[i];
			assign b_prev = b_w[i];
		end else begin : g_body_prev
			assign a_prev = a_w[i-1];
			assign b_prev = b_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign a_next = a_w[i];
			assign b_next = b_w[i];
		end else begin : g_body_next
			assign a_next = a_w[i+1];
			assign b_next = b_w[i+1];
		end

		rse_cell u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.idx    (IDX_W'(i)),
			.a_prev (a_prev),
			.a_next (a_next),
			.b_prev (b_prev),
			.b_next (b_next),
			.a_q    (a_w[i]),
			.b_q    (b_w[i])
		);
	end

	assign a_top = a_w[0];
	assign b_bot = b_w[0];

endmodule
